// ===== rtl/exprtok_pkg.sv =====
// Shared types and constants for the expression tokenizer.
// Used by exprtok_scan, exprtok_queue, exprtok_emit and expression_tokenizer.
package exprtok_pkg;

    localparam int OFFSET_WIDTH = 24;
    localparam int LINE_WIDTH   = 20;
    localparam int CP_WIDTH     = 21;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX  = '1;
    localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;

    // Character codes the scanner looks for
    localparam logic [CP_WIDTH-1:0] CP_LPAREN = 21'd40;
    localparam logic [CP_WIDTH-1:0] CP_RPAREN = 21'd41;
    localparam logic [CP_WIDTH-1:0] CP_PLUS   = 21'd43;
    localparam logic [CP_WIDTH-1:0] CP_MINUS  = 21'd45;
    localparam logic [CP_WIDTH-1:0] CP_STAR   = 21'd42;
    localparam logic [CP_WIDTH-1:0] CP_SLASH  = 21'd47;
    localparam logic [CP_WIDTH-1:0] CP_LF     = 21'd10;
    localparam logic [CP_WIDTH-1:0] CP_CR     = 21'd13;
    localparam logic [CP_WIDTH-1:0] CP_SPACE  = 21'd32;
    localparam logic [CP_WIDTH-1:0] CP_DQUOTE = 21'd34;
    localparam logic [CP_WIDTH-1:0] CP_SQUOTE = 21'd39;
    localparam logic [CP_WIDTH-1:0] CP_DOT    = 21'd46;
    localparam logic [CP_WIDTH-1:0] CP_ZERO   = 21'd48;
    localparam logic [CP_WIDTH-1:0] CP_NINE   = 21'd57;

    typedef enum logic [3:0] {
        TOK_LPAREN  = 4'd0,
        TOK_RPAREN  = 4'd1,
        TOK_PLUS    = 4'd2,
        TOK_MINUS   = 4'd3,
        TOK_MUL     = 4'd4,
        TOK_DIV     = 4'd5,
        TOK_NEWLINE = 4'd6,
        TOK_STRING  = 4'd7,
        TOK_NUMBER  = 4'd8,
        TOK_EOF     = 4'd9
    } tok_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_UNEXPECTED   = 2'd1,
        ERR_UNTERMINATED = 2'd2
    } err_code_t;

    typedef struct packed {
        tok_kind_t               kind;
        err_code_t               err;
        logic [LINE_WIDTH-1:0]   line;
        logic [OFFSET_WIDTH-1:0] start;
        logic [OFFSET_WIDTH-1:0] length;
    } result_t;

    // One queue entry: all results caused by one input item
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

endpackage

// ===== rtl/expression_tokenizer.sv =====
// Expression tokenizer top level.
// Each item's results are registered in the queue before they are offered; characters
// are taken one per cycle while the queue is not full, results leave one per cycle
// while out_ready is high, and an item with two results is absorbed by a 4-entry queue.
// Reset: asynchronous, active low; scanner idle at line 1, offset 0, queue empty.
module expression_tokenizer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 action,
    input  logic [exprtok_pkg::CP_WIDTH-1:0]     code_point,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [3:0]                           token_kind,
    output logic [1:0]                           error_code,
    output logic [exprtok_pkg::LINE_WIDTH-1:0]   line_number,
    output logic [exprtok_pkg::OFFSET_WIDTH-1:0] start_offset,
    output logic [exprtok_pkg::OFFSET_WIDTH-1:0] text_length,
    output logic                                 last
);

    logic                fire;
    logic                push;
    logic                full;
    logic                pop;
    logic                empty;
    exprtok_pkg::entry_t push_data;
    exprtok_pkg::entry_t head;

    assign in_ready = !full;
    assign fire     = in_valid && in_ready;

    exprtok_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .action     (action),
        .code_point (code_point),
        .push       (push),
        .push_data  (push_data)
    );

    exprtok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    exprtok_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .error_code   (error_code),
        .line_number  (line_number),
        .start_offset (start_offset),
        .text_length  (text_length),
        .last         (last)
    );

endmodule

// ===== rtl/exprtok_scan.sv =====
// Front end: accepts characters, runs the scan state machine and builds
// the result pair for each item. Depends on exprtok_pkg.
module exprtok_scan (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  logic                                action,
    input  logic [exprtok_pkg::CP_WIDTH-1:0]    code_point,
    output logic                                push,
    output exprtok_pkg::entry_t                 push_data
);

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_SLASH   = 3'd1,
        M_COMMENT = 3'd2,
        M_STRING  = 3'd3,
        M_INT     = 3'd4,
        M_DOT     = 3'd5,
        M_FRAC    = 3'd6,
        M_HALT    = 3'd7
    } mode_t;

    mode_t                                mode_reg,   mode_next;
    logic                                 single_reg, single_next;
    logic [exprtok_pkg::LINE_WIDTH-1:0]   line_reg,   line_next;
    logic [exprtok_pkg::OFFSET_WIDTH-1:0] offset_reg, offset_next;
    logic [exprtok_pkg::OFFSET_WIDTH-1:0] start_reg,  start_next;
    logic [exprtok_pkg::OFFSET_WIDTH-1:0] length_reg, length_next;

    exprtok_pkg::result_t res_v [2];
    logic [1:0]           n_v;
    logic                 disp_v;
    logic                 digit;
    logic [exprtok_pkg::OFFSET_WIDTH-1:0] cur;
    logic [exprtok_pkg::OFFSET_WIDTH:0]   end_sum;
    logic [exprtok_pkg::OFFSET_WIDTH:0]   len_plus2;
    logic [exprtok_pkg::OFFSET_WIDTH-1:0] dot_pos;

    function automatic logic [exprtok_pkg::OFFSET_WIDTH-1:0] sat_inc_off(
        input logic [exprtok_pkg::OFFSET_WIDTH-1:0] v
    );
        return (v == exprtok_pkg::OFF_MAX) ? v : v + 1'b1;
    endfunction

    function automatic exprtok_pkg::result_t mk(
        input exprtok_pkg::tok_kind_t               kind,
        input exprtok_pkg::err_code_t               err,
        input logic [exprtok_pkg::LINE_WIDTH-1:0]   line,
        input logic [exprtok_pkg::OFFSET_WIDTH-1:0] start,
        input logic [exprtok_pkg::OFFSET_WIDTH-1:0] len
    );
        exprtok_pkg::result_t r;
        r.kind   = kind;
        r.err    = err;
        r.line   = line;
        r.start  = start;
        r.length = len;
        return r;
    endfunction

    assign digit = (code_point >= exprtok_pkg::CP_ZERO) && (code_point <= exprtok_pkg::CP_NINE);
    assign cur   = offset_reg;

    // Saturating sums for the dot error position and the fraction length
    assign end_sum   = {1'b0, start_reg} + {1'b0, length_reg};
    assign dot_pos   = (end_sum >= {1'b0, exprtok_pkg::OFF_MAX})
                       ? exprtok_pkg::OFF_MAX : end_sum[exprtok_pkg::OFFSET_WIDTH-1:0];
    assign len_plus2 = {1'b0, length_reg} + (exprtok_pkg::OFFSET_WIDTH+1)'(2);

    // Next state and results for the item on the input
    always_comb
    begin
        mode_next   = mode_reg;
        single_next = single_reg;
        line_next   = line_reg;
        offset_next = offset_reg;
        start_next  = start_reg;
        length_next = length_reg;
        res_v[0]    = '0;
        res_v[1]    = '0;
        n_v         = 2'd0;
        disp_v      = 1'b0;

        if (fire && (mode_reg != M_HALT))
        begin
            if (action)
            begin
                // End of source: flush the open token, then eof or error
                case (mode_reg)
                    M_SLASH:
                    begin
                        res_v[0] = mk(exprtok_pkg::TOK_DIV, exprtok_pkg::ERR_NONE,
                                      line_reg, start_reg, '0);
                        res_v[1] = mk(exprtok_pkg::TOK_EOF, exprtok_pkg::ERR_NONE,
                                      line_reg, cur, '0);
                        n_v = 2'd2;
                    end
                    M_STRING:
                    begin
                        // error results carry kind zero
                        res_v[0] = mk(exprtok_pkg::TOK_LPAREN,
                                      exprtok_pkg::ERR_UNTERMINATED, line_reg, cur, '0);
                        n_v = 2'd1;
                    end
                    M_INT, M_FRAC:
                    begin
                        res_v[0] = mk(exprtok_pkg::TOK_NUMBER, exprtok_pkg::ERR_NONE,
                                      line_reg, start_reg, length_reg);
                        res_v[1] = mk(exprtok_pkg::TOK_EOF, exprtok_pkg::ERR_NONE,
                                      line_reg, cur, '0);
                        n_v = 2'd2;
                    end
                    M_DOT:
                    begin
                        res_v[0] = mk(exprtok_pkg::TOK_NUMBER, exprtok_pkg::ERR_NONE,
                                      line_reg, start_reg, length_reg);
                        res_v[1] = mk(exprtok_pkg::TOK_LPAREN, exprtok_pkg::ERR_UNEXPECTED,
                                      line_reg, dot_pos, '0);
                        n_v = 2'd2;
                    end
                    default:
                    begin
                        res_v[0] = mk(exprtok_pkg::TOK_EOF, exprtok_pkg::ERR_NONE,
                                      line_reg, cur, '0);
                        n_v = 2'd1;
                    end
                endcase
                mode_next = M_HALT;
            end
            else
            begin
                // Character: advance the open token or close it and dispatch
                case (mode_reg)
                    M_SLASH:
                    begin
                        if (code_point == exprtok_pkg::CP_SLASH)
                        begin
                            mode_next = M_COMMENT;
                        end
                        else
                        begin
                            res_v[0]  = mk(exprtok_pkg::TOK_DIV, exprtok_pkg::ERR_NONE,
                                           line_reg, start_reg, '0);
                            n_v       = 2'd1;
                            mode_next = M_IDLE;
                            disp_v    = 1'b1;
                        end
                    end
                    M_COMMENT:
                    begin
                        if (code_point == exprtok_pkg::CP_LF)
                        begin
                            mode_next = M_IDLE;
                            disp_v    = 1'b1;
                        end
                    end
                    M_STRING:
                    begin
                        if (code_point == (single_reg ? exprtok_pkg::CP_SQUOTE
                                                      : exprtok_pkg::CP_DQUOTE))
                        begin
                            res_v[0]  = mk(exprtok_pkg::TOK_STRING, exprtok_pkg::ERR_NONE,
                                           line_reg, start_reg, length_reg);
                            n_v       = 2'd1;
                            mode_next = M_IDLE;
                        end
                        else if (code_point == exprtok_pkg::CP_LF)
                        begin
                            res_v[0]  = mk(exprtok_pkg::TOK_LPAREN,
                                           exprtok_pkg::ERR_UNTERMINATED, line_reg, cur, '0);
                            n_v       = 2'd1;
                            mode_next = M_HALT;
                        end
                        else
                        begin
                            length_next = sat_inc_off(length_reg);
                        end
                    end
                    M_INT:
                    begin
                        if (digit)
                        begin
                            length_next = sat_inc_off(length_reg);
                        end
                        else if (code_point == exprtok_pkg::CP_DOT)
                        begin
                            mode_next = M_DOT;
                        end
                        else
                        begin
                            res_v[0]  = mk(exprtok_pkg::TOK_NUMBER, exprtok_pkg::ERR_NONE,
                                           line_reg, start_reg, length_reg);
                            n_v       = 2'd1;
                            mode_next = M_IDLE;
                            disp_v    = 1'b1;
                        end
                    end
                    M_DOT:
                    begin
                        if (digit)
                        begin
                            length_next = (len_plus2 >= {1'b0, exprtok_pkg::OFF_MAX})
                                ? exprtok_pkg::OFF_MAX
                                : len_plus2[exprtok_pkg::OFFSET_WIDTH-1:0];
                            mode_next   = M_FRAC;
                        end
                        else
                        begin
                            res_v[0]  = mk(exprtok_pkg::TOK_NUMBER, exprtok_pkg::ERR_NONE,
                                           line_reg, start_reg, length_reg);
                            res_v[1]  = mk(exprtok_pkg::TOK_LPAREN, exprtok_pkg::ERR_UNEXPECTED,
                                           line_reg, dot_pos, '0);
                            n_v       = 2'd2;
                            mode_next = M_HALT;
                        end
                    end
                    M_FRAC:
                    begin
                        if (digit)
                        begin
                            length_next = sat_inc_off(length_reg);
                        end
                        else
                        begin
                            res_v[0]  = mk(exprtok_pkg::TOK_NUMBER, exprtok_pkg::ERR_NONE,
                                           line_reg, start_reg, length_reg);
                            n_v       = 2'd1;
                            mode_next = M_IDLE;
                            disp_v    = 1'b1;
                        end
                    end
                    default:
                    begin
                        disp_v = 1'b1;
                    end
                endcase

                // Dispatch the character from idle
                if (disp_v)
                begin
                    if (code_point == exprtok_pkg::CP_LPAREN)
                    begin
                        res_v[n_v[0]] = mk(exprtok_pkg::TOK_LPAREN, exprtok_pkg::ERR_NONE,
                                           line_next, cur, '0);
                        n_v = n_v + 2'd1;
                    end
                    else if (code_point == exprtok_pkg::CP_RPAREN)
                    begin
                        res_v[n_v[0]] = mk(exprtok_pkg::TOK_RPAREN, exprtok_pkg::ERR_NONE,
                                           line_next, cur, '0);
                        n_v = n_v + 2'd1;
                    end
                    else if (code_point == exprtok_pkg::CP_PLUS)
                    begin
                        res_v[n_v[0]] = mk(exprtok_pkg::TOK_PLUS, exprtok_pkg::ERR_NONE,
                                           line_next, cur, '0);
                        n_v = n_v + 2'd1;
                    end
                    else if (code_point == exprtok_pkg::CP_MINUS)
                    begin
                        res_v[n_v[0]] = mk(exprtok_pkg::TOK_MINUS, exprtok_pkg::ERR_NONE,
                                           line_next, cur, '0);
                        n_v = n_v + 2'd1;
                    end
                    else if (code_point == exprtok_pkg::CP_STAR)
                    begin
                        res_v[n_v[0]] = mk(exprtok_pkg::TOK_MUL, exprtok_pkg::ERR_NONE,
                                           line_next, cur, '0);
                        n_v = n_v + 2'd1;
                    end
                    else if (code_point == exprtok_pkg::CP_SLASH)
                    begin
                        mode_next  = M_SLASH;
                        start_next = cur;
                    end
                    else if ((code_point == exprtok_pkg::CP_SPACE) ||
                             (code_point == exprtok_pkg::CP_CR))
                    begin
                        // skip blanks
                        mode_next = M_IDLE;
                    end
                    else if (code_point == exprtok_pkg::CP_LF)
                    begin
                        line_next = (line_reg == exprtok_pkg::LINE_MAX)
                                    ? line_reg : line_reg + 1'b1;
                        res_v[n_v[0]] = mk(exprtok_pkg::TOK_NEWLINE, exprtok_pkg::ERR_NONE,
                                           line_next, cur, '0);
                        n_v = n_v + 2'd1;
                    end
                    else if ((code_point == exprtok_pkg::CP_DQUOTE) ||
                             (code_point == exprtok_pkg::CP_SQUOTE))
                    begin
                        mode_next   = M_STRING;
                        single_next = (code_point == exprtok_pkg::CP_SQUOTE);
                        start_next  = sat_inc_off(cur);
                        length_next = '0;
                    end
                    else if (digit)
                    begin
                        mode_next   = M_INT;
                        start_next  = cur;
                        length_next = exprtok_pkg::OFFSET_WIDTH'(1);
                    end
                    else
                    begin
                        res_v[n_v[0]] = mk(exprtok_pkg::TOK_LPAREN, exprtok_pkg::ERR_UNEXPECTED,
                                           line_next, cur, '0);
                        n_v = n_v + 2'd1;
                        mode_next = M_HALT;
                    end
                end

                offset_next = sat_inc_off(offset_reg);
            end
        end
    end

    // Hand the result pair to the queue
    assign push         = fire && (n_v != 2'd0);
    assign push_data.two = n_v[1];
    assign push_data.r0  = res_v[0];
    assign push_data.r1  = res_v[1];

    // Hold scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            single_reg <= 1'b0;
            line_reg   <= exprtok_pkg::LINE_WIDTH'(1);
            offset_reg <= '0;
            start_reg  <= '0;
            length_reg <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            single_reg <= single_next;
            line_reg   <= line_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            length_reg <= length_next;
        end
    end

endmodule

// ===== rtl/exprtok_queue.sv =====
// Short queue of result pairs between scanner and output stage.
// Depends on exprtok_pkg.
module exprtok_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  exprtok_pkg::entry_t push_data,
    output logic                full,
    input  logic                pop,
    output exprtok_pkg::entry_t head,
    output logic                empty
);

    exprtok_pkg::entry_t              mem_reg [exprtok_pkg::QUEUE_DEPTH];
    logic [exprtok_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [exprtok_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [exprtok_pkg::QUEUE_CW-1:0] count_reg,  count_next;

    assign full  = (count_reg == exprtok_pkg::QUEUE_CW'(exprtok_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/exprtok_emit.sv =====
// Back end: drains queue entries and sends their results one per transfer.
// Depends on exprtok_pkg.
module exprtok_emit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  exprtok_pkg::entry_t                  head,
    input  logic                                 empty,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [3:0]                           token_kind,
    output logic [1:0]                           error_code,
    output logic [exprtok_pkg::LINE_WIDTH-1:0]   line_number,
    output logic [exprtok_pkg::OFFSET_WIDTH-1:0] start_offset,
    output logic [exprtok_pkg::OFFSET_WIDTH-1:0] text_length,
    output logic                                 last
);

    logic                 second_reg, second_next;
    logic                 xfer;
    exprtok_pkg::result_t cur_res;

    assign out_valid = !empty;
    assign xfer      = out_valid && out_ready;
    assign cur_res   = second_reg ? head.r1 : head.r0;
    assign last      = second_reg || !head.two;
    assign pop       = xfer && last;

    assign token_kind   = cur_res.kind;
    assign error_code   = cur_res.err;
    assign line_number  = cur_res.line;
    assign start_offset = cur_res.start;
    assign text_length  = cur_res.length;

    // Step to the second result of a pair, back to the first on pop
    always_comb
    begin
        second_next = second_reg;
        if (xfer)
        begin
            second_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
        end
    end

endmodule

// ===== bench/expression_tokenizer_checker.sv =====
// Scoreboard for the expression tokenizer: watches both channels, rebuilds the
// expected token stream and compares every output transfer against it.
// Depends on exprtok_pkg for token kinds, error codes and character codes.
module expression_tokenizer_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 action,
    input  logic [exprtok_pkg::CP_WIDTH-1:0]     code_point,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [3:0]                           token_kind,
    input  logic [1:0]                           error_code,
    input  logic [exprtok_pkg::LINE_WIDTH-1:0]   line_number,
    input  logic [exprtok_pkg::OFFSET_WIDTH-1:0] start_offset,
    input  logic [exprtok_pkg::OFFSET_WIDTH-1:0] text_length,
    input  logic                                 last,
    output int                                   mismatches,
    output int                                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        SCAN_IDLE    = 3'd0,
        SCAN_SLASH   = 3'd1,
        SCAN_COMMENT = 3'd2,
        SCAN_STRING  = 3'd3,
        SCAN_INT     = 3'd4,
        SCAN_DOT     = 3'd5,
        SCAN_FRAC    = 3'd6,
        SCAN_HALT    = 3'd7
    } scan_mode_t;

    typedef struct packed {
        exprtok_pkg::result_t res;
        logic                 fin;
    } token_rec_t;

    // Shadow scanner state
    scan_mode_t                           mode;
    logic                                 quote_single;
    logic [exprtok_pkg::LINE_WIDTH-1:0]   line_cnt;
    logic [exprtok_pkg::OFFSET_WIDTH-1:0] src_offset;
    logic [exprtok_pkg::OFFSET_WIDTH-1:0] tok_start;
    logic [exprtok_pkg::OFFSET_WIDTH-1:0] tok_len;

    // Tokens raised by the current character, then the queue of expected tokens
    token_rec_t stage [2];
    int         stage_n;
    token_rec_t expected_tokens [$];
    token_rec_t want;
    int         fail_count;

    function automatic logic [exprtok_pkg::OFFSET_WIDTH-1:0] off_sat_add(
        input logic [exprtok_pkg::OFFSET_WIDTH-1:0] a,
        input logic [exprtok_pkg::OFFSET_WIDTH-1:0] b
    );
        logic [exprtok_pkg::OFFSET_WIDTH:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum >= {1'b0, exprtok_pkg::OFF_MAX})
               ? exprtok_pkg::OFF_MAX : sum[exprtok_pkg::OFFSET_WIDTH-1:0];
    endfunction

    function automatic logic is_digit(input logic [exprtok_pkg::CP_WIDTH-1:0] c);
        return (c >= exprtok_pkg::CP_ZERO) && (c <= exprtok_pkg::CP_NINE);
    endfunction

    task automatic stage_token(
        input exprtok_pkg::tok_kind_t               k,
        input exprtok_pkg::err_code_t               e,
        input logic [exprtok_pkg::OFFSET_WIDTH-1:0] s,
        input logic [exprtok_pkg::OFFSET_WIDTH-1:0] len
    );
        stage[stage_n].res = '{kind: k, err: e, line: line_cnt, start: s, length: len};
        stage[stage_n].fin = 1'b0;
        stage_n++;
    endtask

    task automatic stage_number();
        stage_token(exprtok_pkg::TOK_NUMBER, exprtok_pkg::ERR_NONE, tok_start, tok_len);
    endtask

    // Start a new token from a character seen while idle
    task automatic scan_idle(
        input logic [exprtok_pkg::CP_WIDTH-1:0]     c,
        input logic [exprtok_pkg::OFFSET_WIDTH-1:0] cur
    );
        case (c)
            exprtok_pkg::CP_LPAREN:
                stage_token(exprtok_pkg::TOK_LPAREN, exprtok_pkg::ERR_NONE, cur, '0);
            exprtok_pkg::CP_RPAREN:
                stage_token(exprtok_pkg::TOK_RPAREN, exprtok_pkg::ERR_NONE, cur, '0);
            exprtok_pkg::CP_PLUS:
                stage_token(exprtok_pkg::TOK_PLUS, exprtok_pkg::ERR_NONE, cur, '0);
            exprtok_pkg::CP_MINUS:
                stage_token(exprtok_pkg::TOK_MINUS, exprtok_pkg::ERR_NONE, cur, '0);
            exprtok_pkg::CP_STAR:
                stage_token(exprtok_pkg::TOK_MUL, exprtok_pkg::ERR_NONE, cur, '0);
            exprtok_pkg::CP_SLASH:
            begin
                mode      = SCAN_SLASH;
                tok_start = cur;
            end
            exprtok_pkg::CP_SPACE, exprtok_pkg::CP_CR: ;
            exprtok_pkg::CP_LF:
            begin
                line_cnt = (line_cnt == exprtok_pkg::LINE_MAX)
                           ? exprtok_pkg::LINE_MAX : line_cnt + 1'b1;
                stage_token(exprtok_pkg::TOK_NEWLINE, exprtok_pkg::ERR_NONE, cur, '0);
            end
            exprtok_pkg::CP_DQUOTE, exprtok_pkg::CP_SQUOTE:
            begin
                mode         = SCAN_STRING;
                quote_single = (c == exprtok_pkg::CP_SQUOTE);
                tok_start    = off_sat_add(cur, exprtok_pkg::OFFSET_WIDTH'(1));
                tok_len      = '0;
            end
            default:
            begin
                if (is_digit(c))
                begin
                    mode      = SCAN_INT;
                    tok_start = cur;
                    tok_len   = exprtok_pkg::OFFSET_WIDTH'(1);
                end
                else
                begin
                    // error results carry a zero kind
                    stage_token(exprtok_pkg::TOK_LPAREN, exprtok_pkg::ERR_UNEXPECTED,
                                cur, '0);
                    mode = SCAN_HALT;
                end
            end
        endcase
    endtask

    // Advance the shadow scanner by one accepted item and queue its tokens
    task automatic predict_tokens(
        input logic                           is_end,
        input logic [exprtok_pkg::CP_WIDTH-1:0] c
    );
        logic [exprtok_pkg::OFFSET_WIDTH-1:0] cur;
        token_rec_t                           rec;
        int                                   i;
        cur     = src_offset;
        stage_n = 0;
        if (mode == SCAN_HALT)
            return;
        if (is_end)
        begin
            case (mode)
                SCAN_SLASH:
                begin
                    stage_token(exprtok_pkg::TOK_DIV, exprtok_pkg::ERR_NONE, tok_start, '0);
                    stage_token(exprtok_pkg::TOK_EOF, exprtok_pkg::ERR_NONE, cur, '0);
                end
                SCAN_STRING:
                    stage_token(exprtok_pkg::TOK_LPAREN, exprtok_pkg::ERR_UNTERMINATED,
                                cur, '0);
                SCAN_INT, SCAN_FRAC:
                begin
                    stage_number();
                    stage_token(exprtok_pkg::TOK_EOF, exprtok_pkg::ERR_NONE, cur, '0);
                end
                SCAN_DOT:
                begin
                    stage_number();
                    stage_token(exprtok_pkg::TOK_LPAREN, exprtok_pkg::ERR_UNEXPECTED,
                                off_sat_add(tok_start, tok_len), '0);
                end
                default: stage_token(exprtok_pkg::TOK_EOF, exprtok_pkg::ERR_NONE, cur, '0);
            endcase
            mode = SCAN_HALT;
        end
        else
        begin
            case (mode)
                SCAN_SLASH:
                begin
                    if (c == exprtok_pkg::CP_SLASH)
                        mode = SCAN_COMMENT;
                    else
                    begin
                        stage_token(exprtok_pkg::TOK_DIV, exprtok_pkg::ERR_NONE,
                                    tok_start, '0);
                        mode = SCAN_IDLE;
                        scan_idle(c, cur);
                    end
                end
                SCAN_COMMENT:
                begin
                    if (c == exprtok_pkg::CP_LF)
                    begin
                        mode = SCAN_IDLE;
                        scan_idle(c, cur);
                    end
                end
                SCAN_STRING:
                begin
                    if (c == (quote_single ? exprtok_pkg::CP_SQUOTE : exprtok_pkg::CP_DQUOTE))
                    begin
                        stage_token(exprtok_pkg::TOK_STRING, exprtok_pkg::ERR_NONE,
                                    tok_start, tok_len);
                        mode = SCAN_IDLE;
                    end
                    else if (c == exprtok_pkg::CP_LF)
                    begin
                        stage_token(exprtok_pkg::TOK_LPAREN, exprtok_pkg::ERR_UNTERMINATED,
                                    cur, '0);
                        mode = SCAN_HALT;
                    end
                    else
                        tok_len = off_sat_add(tok_len, exprtok_pkg::OFFSET_WIDTH'(1));
                end
                SCAN_INT:
                begin
                    if (is_digit(c))
                        tok_len = off_sat_add(tok_len, exprtok_pkg::OFFSET_WIDTH'(1));
                    else if (c == exprtok_pkg::CP_DOT)
                        mode = SCAN_DOT;
                    else
                    begin
                        stage_number();
                        mode = SCAN_IDLE;
                        scan_idle(c, cur);
                    end
                end
                SCAN_DOT:
                begin
                    if (is_digit(c))
                    begin
                        tok_len = off_sat_add(tok_len, exprtok_pkg::OFFSET_WIDTH'(2));
                        mode    = SCAN_FRAC;
                    end
                    else
                    begin
                        // the dot itself is the bad character
                        stage_number();
                        stage_token(exprtok_pkg::TOK_LPAREN, exprtok_pkg::ERR_UNEXPECTED,
                                    off_sat_add(tok_start, tok_len), '0);
                        mode = SCAN_HALT;
                    end
                end
                SCAN_FRAC:
                begin
                    if (is_digit(c))
                        tok_len = off_sat_add(tok_len, exprtok_pkg::OFFSET_WIDTH'(1));
                    else
                    begin
                        stage_number();
                        mode = SCAN_IDLE;
                        scan_idle(c, cur);
                    end
                end
                default: scan_idle(c, cur);
            endcase
            src_offset = off_sat_add(src_offset, exprtok_pkg::OFFSET_WIDTH'(1));
        end
        for (i = 0; i < stage_n; i++)
        begin
            rec     = stage[i];
            rec.fin = (i == stage_n - 1);
            expected_tokens.push_back(rec);
        end
    endtask

    // Predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode         = SCAN_IDLE;
            quote_single = 1'b0;
            line_cnt     = exprtok_pkg::LINE_WIDTH'(1);
            src_offset   = '0;
            tok_start    = '0;
            tok_len      = '0;
            fail_count   = 0;
            expected_tokens.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_tokens(action, code_point);
            if (out_valid && out_ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("token with none expected: kind %0d err %0d start %0d",
                           token_kind, error_code, start_offset);
                    fail_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (token_kind !== want.res.kind)
                    begin
                        $error("token_kind: expected %0d, actual %0d", want.res.kind, token_kind);
                        fail_count++;
                    end
                    if (error_code !== want.res.err)
                    begin
                        $error("error_code: expected %0d, actual %0d", want.res.err, error_code);
                        fail_count++;
                    end
                    if (line_number !== want.res.line)
                    begin
                        $error("line_number: expected %0d, actual %0d",
                               want.res.line, line_number);
                        fail_count++;
                    end
                    if (start_offset !== want.res.start)
                    begin
                        $error("start_offset: expected %0d, actual %0d",
                               want.res.start, start_offset);
                        fail_count++;
                    end
                    if (text_length !== want.res.length)
                    begin
                        $error("text_length: expected %0d, actual %0d",
                               want.res.length, text_length);
                        fail_count++;
                    end
                    if (last !== want.fin)
                    begin
                        $error("last: expected %0d, actual %0d", want.fin, last);
                        fail_count++;
                    end
                end
            end
            mismatches <= fail_count;
            pending    <= expected_tokens.size();
        end
    end

endmodule

// ===== bench/expression_tokenizer_tb.sv =====
// Top of the expression tokenizer bench: clock, reset, character stimulus,
// output back-pressure and the verdict.
// Depends on exprtok_pkg, expression_tokenizer and expression_tokenizer_checker.
module expression_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [exprtok_pkg::CP_WIDTH-1:0] CP_TAB     = 21'd9;
    localparam logic [exprtok_pkg::CP_WIDTH-1:0] CP_LOWER_A = 21'd97;
    localparam logic [exprtok_pkg::CP_WIDTH-1:0] CP_TOP     = 21'h10FFFF;
    localparam logic [exprtok_pkg::CP_WIDTH-1:0] CP_WIDE    = 21'h0FFFFF;

    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int PRELUDE_LEN  = 25;

    // Directed source text: every operator, blanks, empty and nested-quote
    // strings, a fractional number, a division and a comment with wide characters
    localparam logic [exprtok_pkg::CP_WIDTH-1:0] PRELUDE [PRELUDE_LEN] = '{
        exprtok_pkg::CP_LPAREN, exprtok_pkg::CP_RPAREN, exprtok_pkg::CP_PLUS,
        exprtok_pkg::CP_MINUS, exprtok_pkg::CP_STAR, exprtok_pkg::CP_SLASH,
        exprtok_pkg::CP_SPACE, exprtok_pkg::CP_CR, exprtok_pkg::CP_LF,
        exprtok_pkg::CP_DQUOTE, exprtok_pkg::CP_DQUOTE, exprtok_pkg::CP_SQUOTE, CP_TOP,
        exprtok_pkg::CP_DQUOTE, exprtok_pkg::CP_SQUOTE, exprtok_pkg::CP_ZERO,
        exprtok_pkg::CP_NINE, exprtok_pkg::CP_DOT, exprtok_pkg::CP_ZERO + 21'd5,
        exprtok_pkg::CP_SLASH, exprtok_pkg::CP_SLASH, CP_WIDE, exprtok_pkg::CP_LF,
        exprtok_pkg::CP_NINE, exprtok_pkg::CP_LPAREN
    };

    logic                                 clk        = 1'b0;
    logic                                 rst_n      = 1'b0;
    logic                                 in_valid   = 1'b0;
    logic                                 action     = ACT_CHAR;
    logic [exprtok_pkg::CP_WIDTH-1:0]     code_point = '0;
    logic                                 out_ready  = 1'b0;
    logic                                 hold_go    = 1'b0;
    logic                                 in_ready;
    logic                                 out_valid;
    logic [3:0]                           token_kind;
    logic [1:0]                           error_code;
    logic [exprtok_pkg::LINE_WIDTH-1:0]   line_number;
    logic [exprtok_pkg::OFFSET_WIDTH-1:0] start_offset;
    logic [exprtok_pkg::OFFSET_WIDTH-1:0] text_length;
    logic                                 last;
    int                                   mismatches;
    int                                   pending;

    int items_sent;
    int burst_left;
    bit gaps_off;

    always #4 clk = ~clk;

    expression_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .code_point   (code_point),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .error_code   (error_code),
        .line_number  (line_number),
        .start_offset (start_offset),
        .text_length  (text_length),
        .last         (last)
    );

    expression_tokenizer_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .code_point   (code_point),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .error_code   (error_code),
        .line_number  (line_number),
        .start_offset (start_offset),
        .text_length  (text_length),
        .last         (last),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // Offer one item, hold it until the transfer, then maybe idle between bursts
    task automatic send_char(input logic is_end, input logic [exprtok_pkg::CP_WIDTH-1:0] cp);
        int gap;
        in_valid   <= 1'b1;
        action     <= is_end;
        code_point <= cp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (!gaps_off && burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else if (burst_left > 0)
            burst_left--;
    endtask

    // Drop valid and wait for every expected token, within a bound
    task automatic wait_drained();
        int n;
        in_valid <= 1'b0;
        @(posedge clk);
        n = 0;
        while (pending != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    function automatic logic [exprtok_pkg::CP_WIDTH-1:0] any_code_point();
        case ($urandom_range(0, 3))
            0:       return exprtok_pkg::CP_WIDTH'($urandom_range(32, 126));
            1:       return exprtok_pkg::CP_WIDTH'($urandom_range(0, 255));
            2:       return exprtok_pkg::CP_WIDTH'($urandom_range(256, CP_TOP));
            default: return exprtok_pkg::CP_WIDTH'($urandom_range(21'h100000, CP_TOP));
        endcase
    endfunction

    function automatic logic [exprtok_pkg::CP_WIDTH-1:0] any_digit();
        return exprtok_pkg::CP_ZERO + exprtok_pkg::CP_WIDTH'($urandom_range(0, 9));
    endfunction

    function automatic logic [exprtok_pkg::CP_WIDTH-1:0] any_operator();
        case ($urandom_range(0, 4))
            0:       return exprtok_pkg::CP_LPAREN;
            1:       return exprtok_pkg::CP_RPAREN;
            2:       return exprtok_pkg::CP_PLUS;
            3:       return exprtok_pkg::CP_MINUS;
            default: return exprtok_pkg::CP_STAR;
        endcase
    endfunction

    task automatic send_digits(input int n);
        repeat (n) send_char(ACT_CHAR, any_digit());
    endtask

    // Integer part, optionally with a fraction
    task automatic send_number(input bit with_fraction);
        send_digits(($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6));
        if (with_fraction)
        begin
            send_char(ACT_CHAR, exprtok_pkg::CP_DOT);
            send_digits($urandom_range(1, 4));
        end
    endtask

    // Opening quote and body; the body never holds a newline or the closing quote
    task automatic send_string_body(input logic [exprtok_pkg::CP_WIDTH-1:0] quote, input int n);
        logic [exprtok_pkg::CP_WIDTH-1:0] c;
        send_char(ACT_CHAR, quote);
        repeat (n)
        begin
            c = any_code_point();
            while (c == exprtok_pkg::CP_LF || c == quote)
                c = any_code_point();
            send_char(ACT_CHAR, c);
        end
    endtask

    task automatic send_comment_body(input int n);
        logic [exprtok_pkg::CP_WIDTH-1:0] c;
        send_char(ACT_CHAR, exprtok_pkg::CP_SLASH);
        send_char(ACT_CHAR, exprtok_pkg::CP_SLASH);
        repeat (n)
        begin
            c = any_code_point();
            while (c == exprtok_pkg::CP_LF)
                c = any_code_point();
            send_char(ACT_CHAR, c);
        end
    endtask

    function automatic logic [exprtok_pkg::CP_WIDTH-1:0] any_quote();
        return $urandom_range(0, 1) ? exprtok_pkg::CP_SQUOTE : exprtok_pkg::CP_DQUOTE;
    endfunction

    // One well-formed token, or a stray blank
    task automatic send_random_token();
        int                               pick;
        logic [exprtok_pkg::CP_WIDTH-1:0] q;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            send_char(ACT_CHAR, any_operator());
        else if (pick < 38)
            send_char(ACT_CHAR, exprtok_pkg::CP_SLASH);
        else if (pick < 48)
            send_char(ACT_CHAR, exprtok_pkg::CP_LF);
        else if (pick < 56)
            send_char(ACT_CHAR, $urandom_range(0, 1) ? exprtok_pkg::CP_SPACE
                                                     : exprtok_pkg::CP_CR);
        else if (pick < 76)
        begin
            // end the number with a blank so a following number stays separate
            send_number($urandom_range(0, 1));
            send_char(ACT_CHAR, exprtok_pkg::CP_SPACE);
        end
        else if (pick < 92)
        begin
            q = any_quote();
            send_string_body(q, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8));
            send_char(ACT_CHAR, q);
        end
        else
        begin
            send_comment_body($urandom_range(0, 6));
            send_char(ACT_CHAR, exprtok_pkg::CP_LF);
        end
    endtask

    // Close the source in one of the ways that halt the scanner, then
    // keep offering items that must be ignored
    task automatic send_finale();
        logic [exprtok_pkg::CP_WIDTH-1:0] bad;
        case ($urandom_range(0, 9))
            0: send_char(ACT_END, any_code_point());
            1:
            begin
                send_char(ACT_CHAR, exprtok_pkg::CP_SLASH);
                send_char(ACT_END, '0);
            end
            2:
            begin
                send_string_body(any_quote(), $urandom_range(0, 5));
                send_char(ACT_END, '0);
            end
            3:
            begin
                send_string_body(any_quote(), $urandom_range(0, 5));
                send_char(ACT_CHAR, exprtok_pkg::CP_LF);
            end
            4:
            begin
                send_number(1'b0);
                send_char(ACT_END, '0);
            end
            5:
            begin
                send_number(1'b1);
                send_char(ACT_END, '0);
            end
            6:
            begin
                send_number(1'b0);
                send_char(ACT_CHAR, exprtok_pkg::CP_DOT);
                send_char(ACT_END, '0);
            end
            7:
            begin
                send_number(1'b0);
                send_char(ACT_CHAR, exprtok_pkg::CP_DOT);
                send_char(ACT_CHAR, $urandom_range(0, 1) ? exprtok_pkg::CP_PLUS : CP_LOWER_A);
            end
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       bad = CP_TAB;
                    1:       bad = CP_LOWER_A + exprtok_pkg::CP_WIDTH'($urandom_range(0, 25));
                    2:       bad = exprtok_pkg::CP_DOT;
                    default: bad = exprtok_pkg::CP_WIDTH'($urandom_range(128, CP_TOP));
                endcase
                send_char(ACT_CHAR, bad);
            end
            default:
            begin
                send_comment_body($urandom_range(0, 4));
                send_char(ACT_END, '0);
            end
        endcase
        repeat (12) send_char($urandom_range(0, 1), any_code_point());
    endtask

    // Output back-pressure: rotating stall patterns, plus one long hold-off
    initial
    begin : receiver
        logic [15:0] stall_pattern;
        int          phase;
        bit          held;
        stall_pattern = '1;
        phase         = 0;
        held          = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (phase == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = 16'($urandom);
                    2:       stall_pattern = 16'($urandom | $urandom);
                    default: stall_pattern = 16'($urandom & $urandom);
                endcase
            end
            out_ready     <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            phase         = (phase + 1) % 48;
        end
    end

    initial
    begin : stimulus
        bit pressured;
        items_sent = 0;
        burst_left = 0;
        gaps_off   = 1'b0;
        pressured  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PRELUDE[k])
            send_char(ACT_CHAR, PRELUDE[k]);

        // hold the sender until the directed tokens are all back
        wait_drained();

        while (items_sent < PRELUDE_LEN + RANDOM_ITEMS)
        begin
            // stall the output while operators keep coming, so the block fills up
            if (!pressured && items_sent >= PRELUDE_LEN + 150)
            begin
                pressured = 1'b1;
                gaps_off  = 1'b1;
                hold_go  <= 1'b1;
                // close any open slash or comment so the operators give tokens
                send_char(ACT_CHAR, exprtok_pkg::CP_LF);
                repeat (30) send_char(ACT_CHAR, any_operator());
                gaps_off  = 1'b0;
            end
            send_random_token();
        end
        send_finale();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/exprtok_pkg.sv
rtl/exprtok_scan.sv
rtl/exprtok_queue.sv
rtl/exprtok_emit.sv
rtl/expression_tokenizer.sv
bench/expression_tokenizer_checker.sv
bench/expression_tokenizer_tb.sv
